/* rtl/core/tspes_pkg.sv */
// Package for the transport stream PES filter core: framing constants,
// packet flag positions, PES status codes and the post status function.
// No dependencies.
package tspes_pkg;

  localparam int unsigned MAX_PES_BYTES = 65536;
  // Count width: wide enough for MAX_PES_BYTES itself, never below the port width
  localparam int CNT_W = ($clog2(MAX_PES_BYTES + 1) > 17) ? $clog2(MAX_PES_BYTES + 1) : 17;

  localparam logic [7:0]  SYNC_BYTE     = 8'h47;
  localparam logic [7:0]  LAST_POS      = 8'd187;
  localparam logic [7:0]  ADAPT_LIMIT   = 8'd183;
  localparam logic [12:0] PID_RESET     = 13'h1fff;
  localparam logic [CNT_W-1:0] HDR_BYTES = CNT_W'(6);

  // packet flag bit positions
  localparam int FL_HI   = 3;  // tei during header bytes, then adaptation field present
  localparam int FL_PUSI = 2;
  localparam int FL_ACC  = 1;
  localparam int FL_PAY  = 0;

  typedef enum logic [2:0] {
    PES_OK        = 3'd0,
    PES_SHORT     = 3'd1,
    PES_BAD_START = 3'd2,
    PES_LEN_ERR   = 3'd3,
    PES_OVERFLOW  = 3'd4
  } pes_status_t;

  function automatic pes_status_t pes_post_status(
    input logic [CNT_W-1:0] cnt,
    input logic             start_bad,
    input logic [15:0]      decl_len,
    input logic             overflow
  );
    logic [CNT_W-1:0] need;
    need = CNT_W'(decl_len) + HDR_BYTES;
    if (cnt < HDR_BYTES)                        return PES_SHORT;
    else if (start_bad)                         return PES_BAD_START;
    else if (decl_len != 16'd0 && need > cnt)   return PES_LEN_ERR;
    else if (overflow)                          return PES_OVERFLOW;
    else                                        return PES_OK;
  endfunction

endpackage

/* rtl/core/ts_pes_filter_core.sv */
// Transport stream PES filter: sync framing, PID selection, continuity check
// and PES reassembly with header checks. Depends on tspes_pkg.
//
// Each accepted byte's result is registered in the output register.
// Throughput: one byte per cycle; the output register is the only stage, and
// in_stall rises only while a held result is stalled downstream.
// Reset (rst_n low, synchronous): hunting for sync, PES state clear,
// pid_select back to 0x1fff, output register empty.
module ts_pes_filter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_pid_select,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_stream_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_payload_valid,
  output logic [7:0]  out_payload_byte,
  output logic [15:0] out_payload_offset,
  output logic        out_pes_done,
  output logic [16:0] out_pes_length,
  output logic [2:0]  out_pes_status,
  output logic        out_cc_error
);
  import tspes_pkg::*;

  logic [12:0]      pid_sel_r;
  logic             in_packet_r, in_packet_nxt;
  logic [7:0]       pos_r, pos_nxt;
  logic [4:0]       pid_hi_r, pid_hi_nxt;
  logic [3:0]       flags_r, flags_nxt;
  logic [7:0]       adapt_r, adapt_nxt;
  logic [3:0]       last_cc_r, last_cc_nxt;
  logic             last_cc_ok_r, last_cc_ok_nxt;
  logic             start_seen_r, start_seen_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             start_bad_r, start_bad_nxt;
  logic [15:0]      decl_r, decl_nxt;

  logic             res_pay_valid, res_done, res_ccerr, res_any;
  logic [7:0]       res_byte;
  logic [CNT_W-1:0] res_offset, res_length;
  pes_status_t      res_status;

  logic             out_valid_r;
  logic             o_pay_valid_r, o_done_r, o_ccerr_r;
  logic [7:0]       o_byte_r;
  logic [15:0]      o_offset_r;
  logic [16:0]      o_length_r;
  pes_status_t      o_status_r;

  logic             in_take, out_take;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_take   = in_valid & ~in_stall;
  assign out_take  = out_valid_r & ~out_stall;

  always_comb begin
    logic [7:0]       b;
    logic [3:0]       cc;
    logic             gap;
    logic             post_req;
    logic [CNT_W-1:0] need;
    b = in_stream_byte;
    in_packet_nxt  = in_packet_r;
    pos_nxt        = pos_r;
    pid_hi_nxt     = pid_hi_r;
    flags_nxt      = flags_r;
    adapt_nxt      = adapt_r;
    last_cc_nxt    = last_cc_r;
    last_cc_ok_nxt = last_cc_ok_r;
    start_seen_nxt = start_seen_r;
    cnt_nxt        = cnt_r;
    ovf_nxt        = ovf_r;
    start_bad_nxt  = start_bad_r;
    decl_nxt       = decl_r;
    res_pay_valid  = 1'b0;
    res_byte       = 8'd0;
    res_offset     = '0;
    res_done       = 1'b0;
    res_length     = '0;
    res_status     = PES_OK;
    res_ccerr      = 1'b0;
    cc             = b[3:0];
    gap            = 1'b0;
    post_req       = 1'b0;
    need           = '0;

    if (!in_packet_r) begin
      // hunt for sync
      if (b == SYNC_BYTE) begin
        in_packet_nxt = 1'b1;
        pos_nxt       = 8'd1;
      end
    end else begin
      if (pos_r == 8'd1) begin
        flags_nxt  = {b[7], b[6], 2'b00};
        pid_hi_nxt = b[4:0];
      end else if (pos_r == 8'd2) begin
        if ({pid_hi_r, b} == pid_sel_r) flags_nxt[FL_ACC] = 1'b1;
      end else if (pos_r == 8'd3) begin
        if (flags_r[FL_ACC]) begin
          gap            = last_cc_ok_r && ((last_cc_r + 4'd1) != cc);
          last_cc_nxt    = cc;
          last_cc_ok_nxt = 1'b1;
          res_ccerr      = gap;
          if (flags_r[FL_PUSI])  start_seen_nxt = 1'b1;
          else if (gap)          start_seen_nxt = 1'b0;
          if (b[7:6] != 2'b00 || flags_r[FL_HI]) start_seen_nxt = 1'b0;
          flags_nxt[FL_HI] = 1'b0;
          if (start_seen_nxt && b[4]) begin
            if (b[5]) begin
              flags_nxt[FL_HI] = 1'b1;
            end else begin
              flags_nxt[FL_PAY] = 1'b1;
              adapt_nxt         = 8'd0;
              post_req          = flags_r[FL_PUSI];
            end
          end
        end
      end else if (pos_r == 8'd4 && flags_r[FL_ACC] && flags_r[FL_HI]) begin
        flags_nxt[FL_HI] = 1'b0;
        if (b < ADAPT_LIMIT) begin
          adapt_nxt         = b;
          flags_nxt[FL_PAY] = 1'b1;
          post_req          = flags_r[FL_PUSI];
        end
      end else if (pos_r >= 8'd4 && flags_r[FL_PAY]) begin
        if (adapt_r != 8'd0) begin
          adapt_nxt = adapt_r - 8'd1;
        end else if (cnt_r >= CNT_W'(MAX_PES_BYTES)) begin
          ovf_nxt = 1'b1;  // drop
        end else begin
          if ((cnt_r == CNT_W'(0) || cnt_r == CNT_W'(1)) && b != 8'd0) start_bad_nxt = 1'b1;
          if (cnt_r == CNT_W'(2) && b != 8'd1) start_bad_nxt = 1'b1;
          if (cnt_r == CNT_W'(4)) decl_nxt = {b, 8'd0};
          if (cnt_r == CNT_W'(5)) decl_nxt = {decl_r[15:8], b};
          res_pay_valid = 1'b1;
          res_byte      = b;
          res_offset    = cnt_r;
          cnt_nxt       = cnt_r + CNT_W'(1);
        end
      end

      if (pos_r >= LAST_POS) begin
        need = CNT_W'(decl_nxt) + HDR_BYTES;
        if (flags_nxt[FL_PAY] && cnt_nxt >= HDR_BYTES && decl_nxt != 16'd0 &&
            cnt_nxt >= need) begin
          post_req       = 1'b1;
          start_seen_nxt = 1'b0;
        end
        in_packet_nxt = 1'b0;
        pos_nxt       = 8'd0;
        flags_nxt     = 4'd0;
        adapt_nxt     = 8'd0;
      end else begin
        pos_nxt = pos_r + 8'd1;
      end

      // post the collected PES and clear its state; an empty one posts nothing
      if (post_req) begin
        if (cnt_nxt != '0) begin
          res_done   = 1'b1;
          res_length = cnt_nxt;
          res_status = pes_post_status(cnt_nxt, start_bad_nxt, decl_nxt, ovf_nxt);
        end
        cnt_nxt       = '0;
        ovf_nxt       = 1'b0;
        start_bad_nxt = 1'b0;
        decl_nxt      = 16'd0;
      end
    end
  end

  assign res_any = res_pay_valid | res_done | res_ccerr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pid_sel_r    <= PID_RESET;
      in_packet_r  <= 1'b0;
      pos_r        <= 8'd0;
      pid_hi_r     <= 5'd0;
      flags_r      <= 4'd0;
      adapt_r      <= 8'd0;
      last_cc_r    <= 4'd0;
      last_cc_ok_r <= 1'b0;
      start_seen_r <= 1'b0;
      cnt_r        <= '0;
      ovf_r        <= 1'b0;
      start_bad_r  <= 1'b0;
      decl_r       <= 16'd0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        pid_sel_r <= cfg_pid_select;
      end
      if (in_take) begin
        in_packet_r  <= in_packet_nxt;
        pos_r        <= pos_nxt;
        pid_hi_r     <= pid_hi_nxt;
        flags_r      <= flags_nxt;
        adapt_r      <= adapt_nxt;
        last_cc_r    <= last_cc_nxt;
        last_cc_ok_r <= last_cc_ok_nxt;
        start_seen_r <= start_seen_nxt;
        cnt_r        <= cnt_nxt;
        ovf_r        <= ovf_nxt;
        start_bad_r  <= start_bad_nxt;
        decl_r       <= decl_nxt;
      end
      // load a new result, or drop the held one once its transaction completes
      if (in_take && res_any) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && res_any) begin
      o_pay_valid_r <= res_pay_valid;
      o_byte_r      <= res_byte;
      o_offset_r    <= res_offset[15:0];
      o_done_r      <= res_done;
      o_length_r    <= res_length[16:0];
      o_status_r    <= res_status;
      o_ccerr_r     <= res_ccerr;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_payload_valid  = o_pay_valid_r;
  assign out_payload_byte   = o_byte_r;
  assign out_payload_offset = o_offset_r;
  assign out_pes_done       = o_done_r;
  assign out_pes_length     = o_length_r;
  assign out_pes_status     = o_status_r;
  assign out_cc_error       = o_ccerr_r;

endmodule
